@@ sv/tlf_pkg.sv @@
`default_nettype none

package tlf_pkg;

	// Received byte values that steer the filter.
	localparam logic [7:0] IAC_BYTE   = 8'hFF;
	localparam logic [7:0] BS_BYTE    = 8'h08;
	localparam logic [7:0] CR_BYTE    = 8'h0D;
	localparam logic [7:0] LF_BYTE    = 8'h0A;
	localparam logic [7:0] SP_BYTE    = 8'h20;
	localparam logic [7:0] TAB_BYTE   = 8'h09;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7F;
	localparam logic [7:0] OPT_CMD_LO = 8'hFB;
	localparam logic [7:0] OPT_CMD_HI = 8'hFE;

	// Edit event kinds.
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_ERASE  = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_DROP   = 2'd3;

	// Telnet command phases.
	localparam logic [1:0] PHASE_DATA = 2'd0;
	localparam logic [1:0] PHASE_CMD  = 2'd1;
	localparam logic [1:0] PHASE_OPT  = 2'd2;

	// Width of the position field.
	localparam int POS_W = 9;

	// One edit event as it leaves the filter.
	typedef struct packed {
		logic [1:0]       event_kind;
		logic [POS_W-1:0] position;
		logic [7:0]       char_out;
	} tlf_event_t;

endpackage

`default_nettype wire

@@ sv/tlf_byte_if.sv @@
`default_nettype none

// Channel that carries one received byte per request.
interface tlf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/tlf_event_if.sv @@
`default_nettype none

// Channel that carries one edit event per request.
interface tlf_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [8:0] position;
	logic [7:0] char_out;

	modport source (output valid, output event_kind, output position, output char_out,
		input ready);
	modport sink (input valid, input event_kind, input position, input char_out,
		output ready);
endinterface

`default_nettype wire

@@ sv/tlf_edit.sv @@
`default_nettype none

// Line editing state and the decision for one byte.
module tlf_edit #(
	parameter int LINE_MAX = 511
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output logic                   has_event,
	output tlf_pkg::tlf_event_t    event_d
);
	import tlf_pkg::*;

	localparam int LEN_W = $clog2(LINE_MAX + 1);

	logic [LEN_W-1:0] len_q, len_d;
	logic             start_q, start_d;
	logic [1:0]       phase_q, phase_d;
	logic [12:0]      len_ext;
	logic [12:0]      len_dec_ext;
	logic [LEN_W-1:0] len_dec;

	assign len_dec     = len_q - LEN_W'(1);
	assign len_ext     = 13'(len_q);
	assign len_dec_ext = 13'(len_dec);

	// Next state and the event, if any, for the byte in hand.
	always_comb begin
		len_d     = len_q;
		start_d   = start_q;
		phase_d   = phase_q;
		has_event = 1'b0;
		event_d   = '0;
		if (phase_q == PHASE_CMD) begin
			phase_d = (rx_byte >= OPT_CMD_LO && rx_byte <= OPT_CMD_HI) ? PHASE_OPT : PHASE_DATA;
		end else if (phase_q != PHASE_DATA) begin
			phase_d = PHASE_DATA;
		end else if (start_q && (rx_byte == SP_BYTE || rx_byte == TAB_BYTE)) begin
			// Leading whitespace is dropped without trace.
		end else begin
			start_d = 1'b0;
			if (rx_byte == IAC_BYTE) begin
				phase_d = PHASE_CMD;
			end else if (rx_byte == CR_BYTE || rx_byte == LF_BYTE) begin
				len_d   = '0;
				start_d = 1'b1;
				if (len_q != '0) begin
					has_event          = 1'b1;
					event_d.event_kind = KIND_DONE;
					event_d.position   = len_ext[POS_W-1:0];
				end
			end else if (rx_byte == BS_BYTE) begin
				if (len_q != '0) begin
					len_d              = len_dec;
					has_event          = 1'b1;
					event_d.event_kind = KIND_ERASE;
					event_d.position   = len_dec_ext[POS_W-1:0];
				end
			end else if (rx_byte >= PRINT_LO && rx_byte <= PRINT_HI) begin
				has_event        = 1'b1;
				event_d.position = len_ext[POS_W-1:0];
				event_d.char_out = rx_byte;
				if (len_q >= LEN_W'(LINE_MAX)) begin
					event_d.event_kind = KIND_DROP;
				end else begin
					event_d.event_kind = KIND_APPEND;
					len_d              = len_q + LEN_W'(1);
				end
			end
		end
	end

	// The state moves on once per byte that is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			start_q <= 1'b1;
			phase_q <= PHASE_DATA;
		end else if (step) begin
			len_q   <= len_d;
			start_q <= start_d;
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/telnet_line_input_filter_core.sv @@
// Channel  Direction  Payload                          Accepted when
// rx       in         rx_byte[7:0]                     rx.valid && rx.ready
// evt      out        event_kind, position, char_out   evt.valid && evt.ready
//
// One byte per cycle sustained while no event byte waits on a stalled event.
// A byte waits in the input register, where the edit state decides on it, and
// its event, if any, is shown from the result register. Reset clears the line
// to empty, at the start of a line, in plain data. A stalled event holds only
// bytes that make an event; bytes that make none still pass through behind it.
`default_nettype none

module telnet_line_input_filter_core #(
	parameter int LINE_MAX = 511
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tlf_byte_if.sink  rx,
	tlf_event_if.source evt
);
	import tlf_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       has_event;
	tlf_event_t event_d;
	tlf_event_t event_q;
	logic       evt_valid_q;
	logic       advance;

	// A byte moves on when it makes no event or the result register is free.
	assign advance  = valid_s1 && (!has_event || !evt_valid_q || evt.ready);
	assign rx.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	tlf_edit #(
		.LINE_MAX(LINE_MAX)
	) u_edit (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.rx_byte  (rx_byte_s1),
		.has_event(has_event),
		.event_d  (event_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (advance && has_event) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_event) begin
			event_q <= event_d;
		end
	end

	assign evt.valid      = evt_valid_q;
	assign evt.event_kind = event_q.event_kind;
	assign evt.position   = event_q.position;
	assign evt.char_out   = event_q.char_out;

endmodule

`default_nettype wire

@@ sv/tlf_checker.sv @@
`default_nettype none

// Checks on what the filter shows at its ports.
module tlf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       evt_valid,
	input wire logic       evt_ready,
	input wire logic [1:0] evt_kind,
	input wire logic [7:0] evt_char
);
	import tlf_pkg::*;

	// A stalled event stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("event withdrawn while stalled");

	// Erase and line complete carry no character.
	a_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt_kind == KIND_ERASE || evt_kind == KIND_DONE) |-> evt_char == 8'h00)
		else $error("erase or complete event carries a character");

	// Appended and dropped characters are printable.
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt_kind == KIND_APPEND || evt_kind == KIND_DROP)
		|-> (evt_char >= PRINT_LO && evt_char <= PRINT_HI))
		else $error("non-printable character in append or drop event");

endmodule

bind telnet_line_input_filter_core tlf_checker u_tlf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.evt_valid(evt.valid),
	.evt_ready(evt.ready),
	.evt_kind (evt.event_kind),
	.evt_char (evt.char_out)
);

`default_nettype wire

@@ sim/tb_telnet_line_input_filter_core.sv @@
`default_nettype none

module tb_telnet_line_input_filter_core;
	import tlf_pkg::*;

	localparam int LINE_LIMIT    = 511;
	localparam int SETTLE_CYCLES = 8;
	localparam int RUN_LIMIT     = 400_000;

	logic clk = 1'b0;
	logic arst_n;

	tlf_byte_if  rx_if ();
	tlf_event_if evt_if ();

	telnet_line_input_filter_core #(
		.LINE_MAX(LINE_LIMIT)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.evt   (evt_if)
	);

	// Shadow of the line editor state.
	int         line_len;
	bit         at_start;
	logic [1:0] cmd_phase;

	tlf_event_t pending_events[$];
	int         fail_count;
	int         idle_pct;
	int         stall_pct;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the edit event, if any, that one received byte causes.
	function automatic void filter_byte(input logic [7:0] b, output bit hit,
		output tlf_event_t ev);
		hit = 1'b0;
		ev  = '0;
		// A byte inside a telnet command is swallowed whatever its value.
		if (cmd_phase == PHASE_CMD) begin
			cmd_phase = (b >= OPT_CMD_LO && b <= OPT_CMD_HI) ? PHASE_OPT : PHASE_DATA;
			return;
		end
		if (cmd_phase != PHASE_DATA) begin
			cmd_phase = PHASE_DATA;
			return;
		end
		if (at_start && (b == SP_BYTE || b == TAB_BYTE))
			return;
		at_start = 1'b0;
		if (b == IAC_BYTE) begin
			cmd_phase = PHASE_CMD;
			return;
		end
		// End of line: only a non-empty line is reported.
		if (b == CR_BYTE || b == LF_BYTE) begin
			at_start = 1'b1;
			if (line_len != 0) begin
				hit = 1'b1;
				ev.event_kind = KIND_DONE;
				ev.position   = POS_W'(line_len);
			end
			line_len = 0;
			return;
		end
		if (b == BS_BYTE) begin
			if (line_len != 0) begin
				line_len--;
				hit = 1'b1;
				ev.event_kind = KIND_ERASE;
				ev.position   = POS_W'(line_len);
			end
			return;
		end
		// Printable characters are appended until the line is full.
		if (b >= PRINT_LO && b <= PRINT_HI) begin
			hit = 1'b1;
			ev.char_out = b;
			ev.position = POS_W'(line_len);
			if (line_len >= LINE_LIMIT) begin
				ev.event_kind = KIND_DROP;
			end else begin
				ev.event_kind = KIND_APPEND;
				line_len++;
			end
		end
	endfunction

	// Checks each event request against the oldest prediction, then predicts
	// from any byte request taken at the same edge.
	always @(posedge clk) begin
		tlf_event_t want;
		bit         hit;
		if (arst_n && evt_if.valid && evt_if.ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event: event_kind=%0d position=%0d char_out=%02h",
					evt_if.event_kind, evt_if.position, evt_if.char_out);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				if (want.event_kind !== evt_if.event_kind) begin
					$error("event_kind: expected %0d, actual %0d",
						want.event_kind, evt_if.event_kind);
					fail_count++;
				end
				if (want.position !== evt_if.position) begin
					$error("position: expected %0d, actual %0d",
						want.position, evt_if.position);
					fail_count++;
				end
				if (want.char_out !== evt_if.char_out) begin
					$error("char_out: expected %02h, actual %02h",
						want.char_out, evt_if.char_out);
					fail_count++;
				end
			end
		end
		if (arst_n && rx_if.valid && rx_if.ready) begin
			filter_byte(rx_if.rx_byte, hit, want);
			if (hit)
				pending_events.push_back(want);
		end
	end

	// The event side stalls at random while stall_pct is non-zero.
	always @(negedge clk) begin
		evt_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// Offers one byte request and waits until it is taken.
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
	endtask

	task automatic send_string(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Spaces and tabs vanish only at the start of a line.
	task automatic test_leading_whitespace();
		send_byte(SP_BYTE);
		send_byte(TAB_BYTE);
		send_byte(SP_BYTE);
		send_string("A \t");
		send_byte(CR_BYTE);
	endtask

	// Empty lines and a backspace on an empty line give nothing; the backspace
	// still ends the leading whitespace.
	task automatic test_empty_lines();
		send_byte(CR_BYTE);
		send_byte(LF_BYTE);
		send_byte(BS_BYTE);
		send_byte(SP_BYTE);
		send_byte(LF_BYTE);
	endtask

	task automatic test_backspace();
		send_string("ab");
		send_byte(BS_BYTE);
		send_byte(BS_BYTE);
		send_byte(BS_BYTE);
		send_byte(PRINT_HI);
		send_byte(LF_BYTE);
	endtask

	// Telnet commands with and without an option byte, including command and
	// option bytes that would otherwise be IAC or a line end.
	task automatic test_telnet_commands();
		send_byte(IAC_BYTE);
		send_byte(8'hF1);
		send_byte(SP_BYTE);
		send_byte(IAC_BYTE);
		send_byte(OPT_CMD_LO);
		send_byte(IAC_BYTE);
		send_byte(IAC_BYTE);
		send_byte(OPT_CMD_HI);
		send_byte(CR_BYTE);
		send_byte(IAC_BYTE);
		send_byte(IAC_BYTE);
		send_byte(IAC_BYTE);
		send_byte(OPT_CMD_LO - 8'd1);
		send_byte(8'h41);
		send_byte(IAC_BYTE);
		send_byte(LF_BYTE);
		send_byte(CR_BYTE);
	endtask

	task automatic test_ignored_bytes();
		send_byte(8'h00);
		send_byte(8'h1F);
		send_byte(8'h80);
		send_byte(OPT_CMD_HI);
		send_byte(PRINT_HI);
		send_byte(PRINT_LO);
		send_byte(CR_BYTE);
	endtask

	// Fills the line, overruns it, frees one place and overruns again.
	task automatic test_line_full();
		for (int i = 0; i < LINE_LIMIT + 3; i++)
			send_byte(8'h21 + 8'(i % 95));
		send_byte(BS_BYTE);
		send_byte(8'h7A);
		send_byte(8'h7E);
		send_byte(CR_BYTE);
	endtask

	// Mostly text lines with edits and telnet commands, plus some noise.
	task automatic run_random_traffic(input int count, input int idle, input int stall);
		int         sent;
		int         r;
		logic [7:0] c;
		idle_pct  = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 55) begin
				send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)));
				sent++;
			end else if (r < 65) begin
				send_byte(BS_BYTE);
				sent++;
			end else if (r < 72) begin
				send_byte($urandom_range(1) ? CR_BYTE : LF_BYTE);
				sent++;
			end else if (r < 78) begin
				send_byte($urandom_range(1) ? SP_BYTE : TAB_BYTE);
				sent++;
			end else if (r < 88) begin
				send_byte(IAC_BYTE);
				c = $urandom_range(1) ? 8'($urandom_range(OPT_CMD_HI, OPT_CMD_LO))
					: 8'($urandom_range(255));
				send_byte(c);
				sent += 2;
				if (c >= OPT_CMD_LO && c <= OPT_CMD_HI) begin
					send_byte(8'($urandom_range(255)));
					sent++;
				end
			end else begin
				send_byte(8'($urandom_range(255)));
				sent++;
			end
		end
		wait_drained();
	endtask

	initial begin
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		evt_if.ready  = 1'b0;
		arst_n        = 1'b0;
		line_len      = 0;
		at_start      = 1'b1;
		cmd_phase     = PHASE_DATA;
		fail_count    = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		test_leading_whitespace();
		test_empty_lines();
		test_backspace();
		test_telnet_commands();
		test_ignored_bytes();
		test_line_full();
		wait_drained();

		run_random_traffic(125, 0, 0);
		run_random_traffic(125, 45, 0);
		run_random_traffic(125, 0, 45);
		run_random_traffic(125, 38, 38);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guards against a hung handshake.
	initial begin
		#RUN_LIMIT;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
